@@ rtl/core/kmeans_2d_clustering_defines.svh @@
// assertion helpers for the clustering core
`ifndef KMEANS_2D_CLUSTERING_DEFINES_SVH
`define KMEANS_2D_CLUSTERING_DEFINES_SVH

// checked outside reset only
`define KMC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define KMC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/kmc_pkg.sv @@
package kmc_pkg;

    localparam int ACTION_W     = 2;
    localparam int SLOT_W       = 4;
    localparam int CLUSTER_W    = 4;
    localparam int MEAN_W       = 21;
    localparam int STEPS_W      = 8;
    localparam int NCL_W        = 5;
    localparam int CFG_W        = 21;
    localparam int CFG_IDX_W    = 2;
    localparam int ERR_W        = 31;
    localparam int RESULT_LIMIT = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_CENTER = 2'd2,
        ACT_RUN    = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CLUSTERS = 2'd0,
        REG_MAX_STEPS    = 2'd1,
        REG_MIN_ERROR    = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PASS,
        S_RD,
        S_DX,
        S_DY,
        S_CMP,
        S_SQ_GO,
        S_SQ_WAIT,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_MEAN_CHK,
        S_UPX,
        S_UPX_WAIT,
        S_UPY_GO,
        S_UPY_WAIT,
        S_UPD_NEXT,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

endpackage

@@ rtl/core/kmc_isqrt.sv @@
module kmc_isqrt #(
    parameter int RW = 44
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [RW-1:0]   radicand,
    output logic            done,
    output logic [RW/2-1:0] root
);
    localparam int RH  = RW / 2;
    localparam int CNT_W = $clog2(RH + 1);

    logic [RW-1:0]    rad_reg;
    logic [RH+1:0]    rem_reg;
    logic [RH-1:0]    root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RH+3:0]    t;
    logic [RH+3:0]    trial;

    assign t     = {rem_reg, rad_reg[RW-1:RW-2]};
    assign trial = (RH+4)'({root_reg, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RW-3:0], 2'b00};
            if (t >= trial)
            begin
                rem_reg  <= (RH+2)'(t - trial);
                root_reg <= {root_reg[RH-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= t[RH+1:0];
                root_reg <= {root_reg[RH-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/core/kmc_div.sv @@
module kmc_div #(
    parameter int NW = 31,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    num_reg;
    logic [DW-1:0]    den_reg;
    logic [DW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      t;

    assign t = {rem_reg, num_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (t >= {1'b0, den_reg})
            begin
                rem_reg <= DW'(t - {1'b0, den_reg});
                num_reg <= {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= t[DW-1:0];
                num_reg <= {num_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

@@ rtl/core/kmeans_2d_clustering.sv @@
// 2d k-means core. load, clear and center items are handled while idle. a run item
// works point by point under one sequencer: per point a memory read, then an x square,
// a y square and a compare per center on one shared squarer, then the start of an
// iterative square root; per pass one mean-error divide when points are loaded and,
// unless the mean error is at or below the minimum, two divides per non-empty center
// on the shared divider. results leave one at a time, each loaded and then held until
// taken, cluster 0 first, with tlast on the final one; no item is taken during a run.
module kmeans_2d_clustering #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CLUSTERS = 16,
    parameter int COORD_BITS   = 12,
    parameter int FRAC_BITS    = 8,
    localparam int CW    = COORD_BITS + FRAC_BITS + 1,
    localparam int IN_W  = ((2 * COORD_BITS + kmc_pkg::SLOT_W + 7) / 8) * 8,
    localparam int OUT_W = ((kmc_pkg::CLUSTER_W + 2 * CW + kmc_pkg::MEAN_W
                            + kmc_pkg::STEPS_W + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kmc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // coord_x, coord_y, slot
    input  logic [IN_W-1:0]                s_tdata,
    // action
    input  logic [kmc_pkg::ACTION_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cluster, center_x, center_y, mean_error, steps_used
    output logic [OUT_W-1:0]               m_tdata,
    output logic                           m_tlast
);
    import kmc_pkg::*;

    localparam int PT_W   = $clog2(MAX_POINTS + 1);
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CI_W   = $clog2(MAX_CLUSTERS);
    localparam int K_LIM  = (MAX_CLUSTERS < RESULT_LIMIT) ? MAX_CLUSTERS : RESULT_LIMIT;
    localparam int SUM_W  = COORD_BITS + PT_W;
    localparam int SQ_W   = 2 * CW + 1;
    localparam int RW     = SQ_W + 1;
    localparam int RH     = RW / 2;
    localparam int UPD_W  = SUM_W + FRAC_BITS + 1;
    localparam int NW     = (UPD_W > ERR_W) ? UPD_W : ERR_W;
    localparam int OUT_PAD = OUT_W - (CLUSTER_W + 2 * CW + MEAN_W + STEPS_W);
    localparam logic [ERR_W-1:0]  ERR_MAX  = '1;
    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

    state_t state_reg, state_next;

    logic [NCL_W-1:0]      ncl_reg;
    logic [STEPS_W-1:0]    max_steps_reg;
    logic [MEAN_W-1:0]     min_err_reg;

    logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
    logic [COORD_BITS-1:0] rd_x_reg;
    logic [COORD_BITS-1:0] rd_y_reg;
    logic [PT_W-1:0]       point_total_reg;
    logic [AW-1:0]         pt_idx_reg;

    logic signed [CW-1:0]  cen_x_reg [MAX_CLUSTERS];
    logic signed [CW-1:0]  cen_y_reg [MAX_CLUSTERS];
    logic [SUM_W-1:0]      sum_x_reg [MAX_CLUSTERS];
    logic [SUM_W-1:0]      sum_y_reg [MAX_CLUSTERS];
    logic [PT_W-1:0]       cnt_reg   [MAX_CLUSTERS];

    logic [CI_W-1:0]       c_idx_reg;
    logic [CI_W-1:0]       k_last_reg;
    logic [CI_W-1:0]       best_idx_reg;
    logic [SQ_W-1:0]       best_reg;
    logic [2*CW-1:0]       sqx_reg;
    logic [SQ_W-1:0]       dist_reg;
    logic [ERR_W-1:0]      err_reg;
    logic [MEAN_W-1:0]     mean_reg;
    logic [STEPS_W-1:0]    steps_reg;
    logic signed [CW-1:0]  new_x_reg;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;
    logic                  out_last_reg;

    logic                  in_fire;
    action_t               act;
    logic [COORD_BITS-1:0] in_x;
    logic [COORD_BITS-1:0] in_y;
    logic [SLOT_W-1:0]     in_slot;
    logic [NCL_W-1:0]      k_clip;

    logic signed [CW:0]    dx;
    logic signed [CW:0]    dy;
    logic [CW-1:0]         ax;
    logic [CW-1:0]         ay;
    logic [CW-1:0]         sq_in;
    logic [2*CW-1:0]       sq_prod;

    logic                  div_start;
    logic [NW-1:0]         div_num;
    logic [PT_W-1:0]       div_den;
    logic                  div_done;
    logic [NW-1:0]         div_q;
    logic                  sq_start;
    logic                  sq_done;
    logic [RH-1:0]         sq_root;
    logic [ERR_W:0]        err_add;

    assign act     = action_t'(s_tuser);
    assign in_x    = s_tdata[COORD_BITS-1:0];
    assign in_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_slot = s_tdata[2*COORD_BITS+SLOT_W-1:2*COORD_BITS];
    assign in_fire = s_tvalid && s_tready;

    always_comb
    begin
        k_clip = (ncl_reg == '0) ? NCL_W'(1) : ncl_reg;
        if (k_clip > NCL_W'(K_LIM))
        begin
            k_clip = NCL_W'(K_LIM);
        end
    end

    assign dx = $signed({2'b00, rd_x_reg, {FRAC_BITS{1'b0}}})
              - {cen_x_reg[c_idx_reg][CW-1], cen_x_reg[c_idx_reg]};
    assign dy = $signed({2'b00, rd_y_reg, {FRAC_BITS{1'b0}}})
              - {cen_y_reg[c_idx_reg][CW-1], cen_y_reg[c_idx_reg]};
    assign ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    assign ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];

    // one squarer shared by both axes
    assign sq_in   = (state_reg == S_DY) ? ay : ax;
    assign sq_prod = sq_in * sq_in;

    assign err_add = {1'b0, err_reg} + (ERR_W+1)'(sq_root);

    always_comb
    begin
        div_num = NW'(err_reg);
        div_den = point_total_reg;
        if (state_reg == S_UPX)
        begin
            div_num = NW'({sum_x_reg[c_idx_reg], {FRAC_BITS{1'b0}}})
                    + NW'(cnt_reg[c_idx_reg] >> 1);
            div_den = cnt_reg[c_idx_reg];
        end
        else if (state_reg == S_UPY_GO)
        begin
            div_num = NW'({sum_y_reg[c_idx_reg], {FRAC_BITS{1'b0}}})
                    + NW'(cnt_reg[c_idx_reg] >> 1);
            div_den = cnt_reg[c_idx_reg];
        end
    end

    kmc_div #(
        .NW (NW),
        .DW (PT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    kmc_isqrt #(
        .RW (RW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (RW'(best_reg)),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && act == ACT_RUN)
                begin
                    state_next = (max_steps_reg == '0) ? S_OUT_LD : S_PASS;
                end
            end
            S_PASS:      state_next = (point_total_reg == '0) ? S_MEAN_GO : S_RD;
            S_RD:        state_next = S_DX;
            S_DX:        state_next = S_DY;
            S_DY:        state_next = S_CMP;
            S_CMP:       state_next = (c_idx_reg == k_last_reg) ? S_SQ_GO : S_DX;
            S_SQ_GO:     state_next = S_SQ_WAIT;
            S_SQ_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = (PT_W'(pt_idx_reg) == point_total_reg - PT_W'(1))
                               ? S_MEAN_GO : S_RD;
                end
            end
            S_MEAN_GO:   state_next = (point_total_reg == '0) ? S_MEAN_CHK : S_MEAN_WAIT;
            S_MEAN_WAIT: state_next = div_done ? S_MEAN_CHK : S_MEAN_WAIT;
            S_MEAN_CHK:  state_next = (mean_reg <= min_err_reg) ? S_OUT_LD : S_UPX;
            S_UPX:       state_next = (cnt_reg[c_idx_reg] == '0) ? S_UPD_NEXT : S_UPX_WAIT;
            S_UPX_WAIT:  state_next = div_done ? S_UPY_GO : S_UPX_WAIT;
            S_UPY_GO:    state_next = S_UPY_WAIT;
            S_UPY_WAIT:  state_next = div_done ? S_UPD_NEXT : S_UPY_WAIT;
            S_UPD_NEXT:
            begin
                if (c_idx_reg != k_last_reg)
                begin
                    state_next = S_UPX;
                end
                else
                begin
                    state_next = (steps_reg == max_steps_reg) ? S_OUT_LD : S_PASS;
                end
            end
            S_OUT_LD:    state_next = S_OUT_WAIT;
            S_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    state_next = out_last_reg ? S_IDLE : S_OUT_LD;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        sq_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:    s_tready  = 1'b1;
            S_SQ_GO:   sq_start  = 1'b1;
            S_MEAN_GO: div_start = (point_total_reg != '0);
            S_UPX:     div_start = (cnt_reg[c_idx_reg] != '0);
            S_UPY_GO:  div_start = 1'b1;
            default:   s_tready  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncl_reg       <= NCL_W'(1);
            max_steps_reg <= STEPS_W'(16);
            min_err_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_NUM_CLUSTERS: ncl_reg       <= cfg_data[NCL_W-1:0];
                REG_MAX_STEPS:    max_steps_reg <= cfg_data[STEPS_W-1:0];
                REG_MIN_ERROR:    min_err_reg   <= cfg_data[MEAN_W-1:0];
                default:          min_err_reg   <= min_err_reg;
            endcase
        end
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (in_fire && act == ACT_LOAD && point_total_reg != PT_W'(MAX_POINTS))
        begin
            mem_x[point_total_reg[AW-1:0]] <= in_x;
            mem_y[point_total_reg[AW-1:0]] <= in_y;
        end
        rd_x_reg <= mem_x[pt_idx_reg];
        rd_y_reg <= mem_y[pt_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_total_reg <= '0;
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                cen_x_reg[i] <= '0;
                cen_y_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
            c_idx_reg     <= '0;
            k_last_reg    <= '0;
            steps_reg     <= '0;
            mean_reg      <= '0;
            pt_idx_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (act)
                            ACT_CLEAR: point_total_reg <= '0;
                            ACT_LOAD:
                            begin
                                if (point_total_reg != PT_W'(MAX_POINTS))
                                begin
                                    point_total_reg <= point_total_reg + PT_W'(1);
                                end
                            end
                            ACT_CENTER:
                            begin
                                if (32'(in_slot) < MAX_CLUSTERS)
                                begin
                                    cen_x_reg[CI_W'(in_slot)] <=
                                        $signed(CW'({in_x, {FRAC_BITS{1'b0}}}));
                                    cen_y_reg[CI_W'(in_slot)] <=
                                        $signed(CW'({in_y, {FRAC_BITS{1'b0}}}));
                                end
                            end
                            ACT_RUN:
                            begin
                                k_last_reg <= CI_W'(k_clip - NCL_W'(1));
                                steps_reg  <= '0;
                                mean_reg   <= '0;
                                c_idx_reg  <= '0;
                            end
                            default: point_total_reg <= point_total_reg;
                        endcase
                    end
                end
                S_PASS:
                begin
                    steps_reg  <= steps_reg + STEPS_W'(1);
                    pt_idx_reg <= '0;
                    c_idx_reg  <= '0;
                end
                S_CMP:
                begin
                    if (c_idx_reg != k_last_reg)
                    begin
                        c_idx_reg <= c_idx_reg + CI_W'(1);
                    end
                end
                S_SQ_GO: c_idx_reg <= '0;
                S_SQ_WAIT:
                begin
                    if (sq_done)
                    begin
                        pt_idx_reg <= pt_idx_reg + AW'(1);
                    end
                end
                S_MEAN_WAIT:
                begin
                    if (div_done)
                    begin
                        mean_reg <= (div_q > NW'(MEAN_MAX)) ? MEAN_MAX : div_q[MEAN_W-1:0];
                    end
                end
                S_MEAN_CHK: c_idx_reg <= '0;
                S_UPX:
                begin
                    if (cnt_reg[c_idx_reg] == '0)
                    begin
                        cen_x_reg[c_idx_reg] <= -$signed(CW'(1 << FRAC_BITS));
                        cen_y_reg[c_idx_reg] <= -$signed(CW'(1 << FRAC_BITS));
                    end
                end
                S_UPY_WAIT:
                begin
                    if (div_done)
                    begin
                        cen_x_reg[c_idx_reg] <= new_x_reg;
                        cen_y_reg[c_idx_reg] <= $signed(div_q[CW-1:0]);
                    end
                end
                S_UPD_NEXT:
                begin
                    c_idx_reg <= (c_idx_reg == k_last_reg) ? '0 : c_idx_reg + CI_W'(1);
                end
                S_OUT_LD: out_valid_reg <= 1'b1;
                S_OUT_WAIT:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        c_idx_reg     <= c_idx_reg + CI_W'(1);
                    end
                end
                default: out_valid_reg <= out_valid_reg;
            endcase
        end
    end

    // pass datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PASS)
        begin
            err_reg <= '0;
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                sum_x_reg[i] <= '0;
                sum_y_reg[i] <= '0;
                cnt_reg[i]   <= '0;
            end
        end
        if (state_reg == S_DX)
        begin
            sqx_reg <= sq_prod;
        end
        if (state_reg == S_DY)
        begin
            dist_reg <= SQ_W'(sqx_reg) + SQ_W'(sq_prod);
        end
        if (state_reg == S_CMP && (c_idx_reg == '0 || dist_reg < best_reg))
        begin
            best_reg     <= dist_reg;
            best_idx_reg <= c_idx_reg;
        end
        if (state_reg == S_SQ_GO)
        begin
            sum_x_reg[best_idx_reg] <= sum_x_reg[best_idx_reg] + SUM_W'(rd_x_reg);
            sum_y_reg[best_idx_reg] <= sum_y_reg[best_idx_reg] + SUM_W'(rd_y_reg);
            cnt_reg[best_idx_reg]   <= cnt_reg[best_idx_reg] + PT_W'(1);
        end
        if (state_reg == S_SQ_WAIT && sq_done)
        begin
            err_reg <= (err_add > (ERR_W+1)'(ERR_MAX)) ? ERR_MAX : err_add[ERR_W-1:0];
        end
        if (state_reg == S_UPX_WAIT && div_done)
        begin
            new_x_reg <= $signed(div_q[CW-1:0]);
        end
        if (state_reg == S_OUT_LD)
        begin
            out_data_reg <= {{OUT_PAD{1'b0}}, steps_reg, mean_reg,
                             cen_y_reg[c_idx_reg], cen_x_reg[c_idx_reg],
                             CLUSTER_W'(c_idx_reg)};
            out_last_reg <= (c_idx_reg == k_last_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`include "kmeans_2d_clustering_defines.svh"

    `KMC_ASSERT_ALWAYS(a_no_overlap, !(s_tready && m_tvalid), "input taken while result pending")
    `KMC_ASSERT(a_store_bound, point_total_reg <= PT_W'(MAX_POINTS), "point count overflow")
    `KMC_ASSERT(a_run_busy, (in_fire && act == ACT_RUN) |=> !s_tready, "ready during run")
    `KMC_ASSERT(a_end_idle, (m_tvalid && m_tready && m_tlast) |=> s_tready, "no return to idle")

endmodule
